// ===== src/grid_cell_neighbour_index_macros.svh =====
// Assertion macros shared by the grid cell index RTL.
`ifndef GRID_CELL_NEIGHBOUR_INDEX_MACROS_SVH
`define GRID_CELL_NEIGHBOUR_INDEX_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define GCNI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define GCNI_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define GCNI_ASSERT(label, clk, rst, prop, msg)

`define GCNI_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== src/gcni_pkg.sv =====
package gcni_pkg;

   // Field widths
   localparam int COORD_BITS  = 24;
   localparam int CELL_W      = 16;
   localparam int CELL_SIZE_W = 24;
   localparam int DIM_W       = 9;
   localparam int CSR_INDEX_W = 2;

   // Divider width covers both a coordinate and a cell index
   localparam int DIV_W = (COORD_BITS > CELL_W) ? COORD_BITS : CELL_W;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_SIZE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLUMNS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS    = 2'd2;

   // Operations
   localparam logic OP_POSITION = 1'b0;
   localparam logic OP_NEIGHBOURS = 1'b1;

   // Neighbourhood slots, in emission order; also bit positions of the slot mask
   localparam int NB_COUNT = 9;
   localparam int NB_SEL_W = 4;
   localparam logic [NB_SEL_W-1:0] NB_SELF  = 4'd0;
   localparam logic [NB_SEL_W-1:0] NB_UL    = 4'd1;
   localparam logic [NB_SEL_W-1:0] NB_UP    = 4'd2;
   localparam logic [NB_SEL_W-1:0] NB_UR    = 4'd3;
   localparam logic [NB_SEL_W-1:0] NB_RIGHT = 4'd4;
   localparam logic [NB_SEL_W-1:0] NB_LR    = 4'd5;
   localparam logic [NB_SEL_W-1:0] NB_DOWN  = 4'd6;
   localparam logic [NB_SEL_W-1:0] NB_LL    = 4'd7;
   localparam logic [NB_SEL_W-1:0] NB_LEFT  = 4'd8;

   typedef struct packed {
      logic                  op;
      logic [COORD_BITS-1:0] x_position;
      logic [COORD_BITS-1:0] y_position;
      logic [CELL_W-1:0]     query_cell;
   } req_word_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_index;
      logic              is_last;
      logic              out_of_range;
   } rsp_word_type;

   // Item data that rides along the divider
   typedef struct packed {
      logic              op;
      logic [CELL_W-1:0] query_cell;
      logic [DIM_W-1:0]  cols;
      logic [DIM_W-1:0]  rows;
      logic              grid_empty;
      logic              size_zero;
   } side_type;

   // One resolved item handed to the result sequencer
   typedef struct packed {
      logic                valid;
      logic                oor;
      logic [CELL_W-1:0]   base;
      logic [NB_COUNT-1:0] mask;
      logic [DIM_W-1:0]    cols;
   } emit_item_type;

endpackage

// ===== src/grid_cell_neighbour_index.sv =====
// Path: a request passes the stages of the DIV_W-bit divider, P1, P2 and the sequencer's
//   item register before its result word is registered; DIV_W is the larger of coordinate width and 16.
// Throughput: one request per cycle for position lookups while the output is not stalled;
//   a neighbourhood query holds the result sequencer while it emits its 1 to 9 words.
// Reset: synchronous, active high; clears all valid bits and loads cell_size 256,
//   grid_columns 16, grid_rows 16.
`include "grid_cell_neighbour_index_macros.svh"

module grid_cell_neighbour_index #(
   parameter int MAX_COLUMNS = 256,
   parameter int MAX_ROWS    = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  gcni_pkg::req_word_type               req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output gcni_pkg::rsp_word_type               rsp_word,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gcni_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gcni_pkg::CELL_SIZE_W-1:0]     csr_wdata
);

   localparam int DIV_W    = gcni_pkg::DIV_W;
   localparam int DS_W     = gcni_pkg::CELL_SIZE_W;
   localparam int DIM_W    = gcni_pkg::DIM_W;
   localparam int CELL_W   = gcni_pkg::CELL_W;
   localparam int NB_COUNT = gcni_pkg::NB_COUNT;
   localparam int IDX_W    = 2 * DIM_W + 1;

   // Configuration registers
   logic [DS_W-1:0]  cell_size_ff;
   logic [DS_W-1:0]  cell_size_in;
   logic [DIM_W-1:0] grid_columns_ff;
   logic [DIM_W-1:0] grid_columns_in;
   logic [DIM_W-1:0] grid_rows_ff;
   logic [DIM_W-1:0] grid_rows_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cell_size_in    = cell_size_ff;
      grid_columns_in = grid_columns_ff;
      grid_rows_in    = grid_rows_ff;
      if (csr_valid) begin
         case (csr_index)
            gcni_pkg::CSR_CELL_SIZE:    cell_size_in    = csr_wdata;
            gcni_pkg::CSR_GRID_COLUMNS: grid_columns_in = csr_wdata[DIM_W-1:0];
            gcni_pkg::CSR_GRID_ROWS:    grid_rows_in    = csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff    <= 24'd256;
         grid_columns_ff <= 9'd16;
         grid_rows_ff    <= 9'd16;
      end else begin
         cell_size_ff    <= cell_size_in;
         grid_columns_ff <= grid_columns_in;
         grid_rows_ff    <= grid_rows_in;
      end
   end

   // Pipeline moves as one when the sequencer can take a new item
   logic adv;
   assign req_stall = !adv;

   // Operand setup for the divider
   logic [DIM_W-1:0]   cols_eff;
   logic [DIM_W-1:0]   rows_eff;
   logic [DIV_W-1:0]   num_a_in;
   logic [DIV_W-1:0]   num_b_in;
   logic [DS_W-1:0]    divisor_in;
   gcni_pkg::side_type side_in;

   always_comb begin
      cols_eff = grid_columns_ff;
      if (int'(grid_columns_ff) > MAX_COLUMNS) begin
         cols_eff = DIM_W'(MAX_COLUMNS);
      end
      rows_eff = grid_rows_ff;
      if (int'(grid_rows_ff) > MAX_ROWS) begin
         rows_eff = DIM_W'(MAX_ROWS);
      end

      side_in.op         = req_word.op;
      side_in.query_cell = req_word.query_cell;
      side_in.cols       = cols_eff;
      side_in.rows       = rows_eff;
      side_in.grid_empty = (cols_eff == '0) || (rows_eff == '0);
      side_in.size_zero  = (cell_size_ff == '0);

      // Neighbourhood query: cell / columns gives row, remainder gives column
      if (req_word.op == gcni_pkg::OP_NEIGHBOURS) begin
         num_a_in   = DIV_W'(req_word.query_cell);
         divisor_in = DS_W'(cols_eff);
      end else begin
         num_a_in   = DIV_W'(req_word.x_position);
         divisor_in = cell_size_ff;
      end
      num_b_in = DIV_W'(req_word.y_position);
   end

   logic               dv_valid;
   logic [DIV_W-1:0]   dv_quo_a;
   logic [DS_W-1:0]    dv_rem_a;
   logic [DIV_W-1:0]   dv_quo_b;
   gcni_pkg::side_type dv_side;

   gcni_div_pipe u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (req_valid),
      .in_num_a   (num_a_in),
      .in_num_b   (num_b_in),
      .in_divisor (divisor_in),
      .in_side    (side_in),
      .out_valid  (dv_valid),
      .out_quo_a  (dv_quo_a),
      .out_rem_a  (dv_rem_a),
      .out_quo_b  (dv_quo_b),
      .out_side   (dv_side)
   );

   // Stage P1: range check, column and row
   logic              p1_valid_ff;
   logic              p1_op_ff;
   logic              p1_oor_ff;
   logic [DIM_W-1:0]  p1_col_ff;
   logic [DIM_W-1:0]  p1_row_ff;
   logic [DIM_W-1:0]  p1_cols_ff;
   logic [DIM_W-1:0]  p1_rows_ff;
   logic [CELL_W-1:0] p1_cell_ff;
   logic              p1_oor_in;
   logic [DIM_W-1:0]  p1_col_in;
   logic [DIM_W-1:0]  p1_row_in;

   always_comb begin
      if (dv_side.op == gcni_pkg::OP_NEIGHBOURS) begin
         p1_oor_in = dv_side.grid_empty || (dv_quo_a >= DIV_W'(dv_side.rows));
         p1_col_in = dv_rem_a[DIM_W-1:0];
         p1_row_in = dv_quo_a[DIM_W-1:0];
      end else begin
         p1_oor_in = dv_side.grid_empty || dv_side.size_zero
                     || (dv_quo_a >= DIV_W'(dv_side.cols))
                     || (dv_quo_b >= DIV_W'(dv_side.rows));
         p1_col_in = dv_quo_a[DIM_W-1:0];
         p1_row_in = dv_quo_b[DIM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_op_ff   <= dv_side.op;
         p1_oor_ff  <= p1_oor_in;
         p1_col_ff  <= p1_col_in;
         p1_row_ff  <= p1_row_in;
         p1_cols_ff <= dv_side.cols;
         p1_rows_ff <= dv_side.rows;
         p1_cell_ff <= dv_side.query_cell;
      end
   end

   // Stage P2: row-major index and neighbour slot mask
   logic [IDX_W-1:0]        idx_wide;
   logic                    at_left;
   logic                    at_right;
   logic                    at_top;
   logic                    at_bottom;
   logic [NB_COUNT-1:0]     nb_mask;
   gcni_pkg::emit_item_type p2_in;
   gcni_pkg::emit_item_type p2_ff;

   always_comb begin
      idx_wide  = IDX_W'(p1_row_ff) * IDX_W'(p1_cols_ff) + IDX_W'(p1_col_ff);
      at_left   = (p1_col_ff == '0);
      at_right  = (p1_col_ff == p1_cols_ff - 9'd1);
      at_top    = (p1_row_ff == '0);
      at_bottom = (p1_row_ff == p1_rows_ff - 9'd1);

      nb_mask                     = '0;
      nb_mask[gcni_pkg::NB_SELF]  = 1'b1;
      nb_mask[gcni_pkg::NB_UL]    = !(at_top || at_left);
      nb_mask[gcni_pkg::NB_UP]    = !at_top;
      nb_mask[gcni_pkg::NB_UR]    = !(at_top || at_right);
      nb_mask[gcni_pkg::NB_RIGHT] = !at_right;
      nb_mask[gcni_pkg::NB_LR]    = !(at_bottom || at_right);
      nb_mask[gcni_pkg::NB_DOWN]  = !at_bottom;
      nb_mask[gcni_pkg::NB_LL]    = !(at_bottom || at_left);
      nb_mask[gcni_pkg::NB_LEFT]  = !at_left;

      p2_in.valid = p1_valid_ff;
      p2_in.oor   = p1_oor_ff;
      p2_in.cols  = p1_cols_ff;
      if (p1_oor_ff) begin
         p2_in.base = '0;
         p2_in.mask = NB_COUNT'(1);
      end else if (p1_op_ff == gcni_pkg::OP_NEIGHBOURS) begin
         p2_in.base = p1_cell_ff;
         p2_in.mask = nb_mask;
      end else begin
         p2_in.base = idx_wide[CELL_W-1:0];
         p2_in.mask = NB_COUNT'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_ff.valid <= 1'b0;
      end else if (adv) begin
         p2_ff.valid <= p2_in.valid;
      end
      if (adv) begin
         p2_ff.oor  <= p2_in.oor;
         p2_ff.base <= p2_in.base;
         p2_ff.mask <= p2_in.mask;
         p2_ff.cols <= p2_in.cols;
      end
   end

   // Result sequencer and output register
   gcni_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .item      (p2_ff),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // Checks
   `GCNI_ASSERT(a_p2_holds_on_stall, clock, reset, p2_ff.valid && !adv |=> p2_ff.valid && $stable(p2_ff.base) && $stable(p2_ff.mask), "pipeline item changed while sequencer busy")
   `GCNI_ASSERT(a_p2_oor_lone_slot, clock, reset, p2_ff.valid && p2_ff.oor |-> (p2_ff.mask == NB_COUNT'(1)) && (p2_ff.base == '0), "off-grid item not a lone zero slot")
   `GCNI_ASSERT(a_csr_always_ready, clock, reset, csr_ready, "register port not ready")

endmodule

// ===== src/gcni_div_pipe.sv =====
// Two-lane restoring divider, one quotient bit per stage, shared divisor.
module gcni_div_pipe (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [gcni_pkg::DIV_W-1:0]          in_num_a,
   input  logic [gcni_pkg::DIV_W-1:0]          in_num_b,
   input  logic [gcni_pkg::CELL_SIZE_W-1:0]    in_divisor,
   input  gcni_pkg::side_type                  in_side,
   output logic                                out_valid,
   output logic [gcni_pkg::DIV_W-1:0]          out_quo_a,
   output logic [gcni_pkg::CELL_SIZE_W-1:0]    out_rem_a,
   output logic [gcni_pkg::DIV_W-1:0]          out_quo_b,
   output gcni_pkg::side_type                  out_side
);

   localparam int DIV_W = gcni_pkg::DIV_W;
   localparam int DS_W  = gcni_pkg::CELL_SIZE_W;

   // Returns {quotient bit, new partial remainder}
   function automatic logic [DS_W:0] div_step(input logic [DS_W-1:0] rem,
                                              input logic bit_in,
                                              input logic [DS_W-1:0] d);
      logic [DS_W:0] trial;
      logic [DS_W:0] diff;
      trial = {rem, bit_in};
      diff  = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
         return {1'b1, diff[DS_W-1:0]};
      end
      return {1'b0, trial[DS_W-1:0]};
   endfunction

   // Per-stage registers: num holds remaining dividend bits high, quotient bits low
   logic                       valid_ff [DIV_W];
   logic [DIV_W-1:0]           num_a_ff [DIV_W];
   logic [DIV_W-1:0]           num_b_ff [DIV_W];
   logic [DS_W-1:0]            rem_a_ff [DIV_W];
   logic [DS_W-1:0]            rem_b_ff [DIV_W];
   logic [DS_W-1:0]            div_ff   [DIV_W];
   gcni_pkg::side_type         side_ff  [DIV_W];

   for (genvar g = 0; g < DIV_W; g++) begin : g_stage
      logic               valid_src;
      logic [DIV_W-1:0]   num_a_src;
      logic [DIV_W-1:0]   num_b_src;
      logic [DS_W-1:0]    rem_a_src;
      logic [DS_W-1:0]    rem_b_src;
      logic [DS_W-1:0]    div_src;
      gcni_pkg::side_type side_src;
      logic [DS_W:0]      step_a;
      logic [DS_W:0]      step_b;
      logic [DIV_W-1:0]   num_a_in;
      logic [DIV_W-1:0]   num_b_in;

      if (g == 0) begin : g_first
         always_comb begin
            valid_src = in_valid;
            num_a_src = in_num_a;
            num_b_src = in_num_b;
            rem_a_src = '0;
            rem_b_src = '0;
            div_src   = in_divisor;
            side_src  = in_side;
         end
      end else begin : g_next
         always_comb begin
            valid_src = valid_ff[g-1];
            num_a_src = num_a_ff[g-1];
            num_b_src = num_b_ff[g-1];
            rem_a_src = rem_a_ff[g-1];
            rem_b_src = rem_b_ff[g-1];
            div_src   = div_ff[g-1];
            side_src  = side_ff[g-1];
         end
      end

      // One trial subtract per lane
      always_comb begin
         step_a   = div_step(rem_a_src, num_a_src[DIV_W-1], div_src);
         step_b   = div_step(rem_b_src, num_b_src[DIV_W-1], div_src);
         num_a_in = {num_a_src[DIV_W-2:0], step_a[DS_W]};
         num_b_in = {num_b_src[DIV_W-2:0], step_b[DS_W]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_a_ff[g] <= num_a_in;
            num_b_ff[g] <= num_b_in;
            rem_a_ff[g] <= step_a[DS_W-1:0];
            rem_b_ff[g] <= step_b[DS_W-1:0];
            div_ff[g]   <= div_src;
            side_ff[g]  <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[DIV_W-1];
   assign out_quo_a = num_a_ff[DIV_W-1];
   assign out_rem_a = rem_a_ff[DIV_W-1];
   assign out_quo_b = num_b_ff[DIV_W-1];
   assign out_side  = side_ff[DIV_W-1];

endmodule

// ===== src/gcni_emit.sv =====
`include "grid_cell_neighbour_index_macros.svh"

// Result sequencer: walks the slot mask of one item, one word per cycle while the output is not stalled.
module gcni_emit (
   input  logic                    clock,
   input  logic                    reset,
   input  gcni_pkg::emit_item_type item,
   output logic                    adv,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output gcni_pkg::rsp_word_type  rsp_word
);

   localparam int CELL_W   = gcni_pkg::CELL_W;
   localparam int NB_COUNT = gcni_pkg::NB_COUNT;
   localparam int NB_SEL_W = gcni_pkg::NB_SEL_W;

   gcni_pkg::emit_item_type item_ff;
   gcni_pkg::emit_item_type item_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   gcni_pkg::rsp_word_type  rsp_word_ff;
   gcni_pkg::rsp_word_type  rsp_word_in;

   logic                    out_free;
   logic                    fire;
   logic [NB_SEL_W-1:0]     slot;
   logic [NB_COUNT-1:0]     remaining;
   logic                    last;
   logic [CELL_W-1:0]       cols_ext;
   logic [CELL_W-1:0]       nb_cell;

   // Pick the lowest pending slot
   always_comb begin
      slot = gcni_pkg::NB_SELF;
      for (int i = NB_COUNT - 1; i >= 0; i--) begin
         if (item_ff.mask[i]) begin
            slot = NB_SEL_W'(i);
         end
      end
      remaining       = item_ff.mask;
      remaining[slot] = 1'b0;
      last            = (remaining == '0);
   end

   // Neighbour cell from the base cell and the row pitch
   always_comb begin
      cols_ext = CELL_W'(item_ff.cols);
      case (slot)
         gcni_pkg::NB_SELF:  nb_cell = item_ff.base;
         gcni_pkg::NB_UL:    nb_cell = item_ff.base - cols_ext - 16'd1;
         gcni_pkg::NB_UP:    nb_cell = item_ff.base - cols_ext;
         gcni_pkg::NB_UR:    nb_cell = item_ff.base - cols_ext + 16'd1;
         gcni_pkg::NB_RIGHT: nb_cell = item_ff.base + 16'd1;
         gcni_pkg::NB_LR:    nb_cell = item_ff.base + cols_ext + 16'd1;
         gcni_pkg::NB_DOWN:  nb_cell = item_ff.base + cols_ext;
         gcni_pkg::NB_LL:    nb_cell = item_ff.base + cols_ext - 16'd1;
         gcni_pkg::NB_LEFT:  nb_cell = item_ff.base - 16'd1;
         default:            nb_cell = item_ff.base;
      endcase
   end

   // Handshake and next state
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      fire     = item_ff.valid && out_free;
      adv      = !item_ff.valid || (fire && last);

      item_in = item_ff;
      if (adv) begin
         item_in = item;
      end else if (fire) begin
         item_in.mask = remaining;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (fire) begin
         rsp_valid_in             = 1'b1;
         rsp_word_in.cell_index   = nb_cell;
         rsp_word_in.is_last      = last;
         rsp_word_in.out_of_range = item_ff.oor;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff.oor  <= item_in.oor;
      item_ff.base <= item_in.base;
      item_ff.mask <= item_in.mask;
      item_ff.cols <= item_in.cols;
      rsp_word_ff  <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Checks
   `GCNI_NEVER(a_held_item_has_slot, clock, reset, item_ff.valid && (item_ff.mask == '0), "held item with empty slot mask")
   `GCNI_ASSERT(a_partial_keeps_item, clock, reset, fire && !last |=> item_ff.valid && (item_ff.mask == $past(remaining)), "item dropped before its last word")
   `GCNI_ASSERT(a_idle_holds_mask, clock, reset, item_ff.valid && !fire |=> item_ff.valid && $stable(item_ff.mask), "slot mask moved without a word going out")
   `GCNI_ASSERT(a_oor_single_word, clock, reset, rsp_valid_ff && rsp_word_ff.out_of_range |-> rsp_word_ff.is_last && (rsp_word_ff.cell_index == '0), "off-grid word not a lone zero word")

endmodule
